// ===== rtl/chdf_pkg.sv =====
// Types, codes and character constants shared by the chunked body deframer.
package chdf_pkg;

   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_9       = 8'h39;
   localparam logic [7:0] CH_LA      = 8'h61;
   localparam logic [7:0] CH_LF_HEX  = 8'h66;
   localparam logic [7:0] CH_UA      = 8'h41;
   localparam logic [7:0] CH_UF      = 8'h46;
   localparam logic [7:0] CH_LX      = 8'h78;
   localparam logic [7:0] CH_UX      = 8'h58;
   localparam logic [3:0] HEX_TEN    = 4'd10;

   localparam logic [31:0] SIZE_LIMIT = 32'h7FFF_FFFF;
   localparam logic [31:0] SHIFT_LIMIT = 32'h07FF_FFFF;
   localparam logic [31:0] SIZE_SAT = 32'h8000_0000;

   typedef enum logic [2:0] {
      PH_SIZE_START  = 3'd0,
      PH_SIZE_DIGITS = 3'd1,
      PH_SIZE_LF     = 3'd2,
      PH_DATA        = 3'd3,
      PH_DATA_CR     = 3'd4,
      PH_DATA_LF     = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_BAD_START  = 3'd1,
      ERR_BAD_CHAR   = 3'd2,
      ERR_NO_LF_SIZE = 3'd3,
      ERR_TOO_LARGE  = 3'd4,
      ERR_NO_CR_DATA = 3'd5,
      ERR_NO_LF_DATA = 3'd6
   } err_type;

   typedef enum logic [1:0] {
      ST_RUN  = 2'd0,
      ST_DONE = 2'd1,
      ST_ERR  = 2'd2
   } status_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] digit;
   } hex_type;

   typedef struct packed {
      logic       restart;
      logic [7:0] in_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        is_payload;
      logic        chunk_end;
      status_type  parse_status;
      err_type     error_code;
      logic [31:0] total_length;
   } rsp_word_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok    = 1'b0;
      h.digit = 4'd0;
      if (c >= CH_0 && c <= CH_9) begin
         h.ok    = 1'b1;
         h.digit = 4'(c - CH_0);
      end else if (c >= CH_LA && c <= CH_LF_HEX) begin
         h.ok    = 1'b1;
         h.digit = 4'(c - CH_LA) + HEX_TEN;
      end else if (c >= CH_UA && c <= CH_UF) begin
         h.ok    = 1'b1;
         h.digit = 4'(c - CH_UA) + HEX_TEN;
      end
      return h;
   endfunction

endpackage

// ===== rtl/chdf_req_if.sv =====
// Input channel: one raw body word with its restart flag.
interface chdf_req_if;
   logic       valid;
   logic       ready;
   logic       restart;
   logic [7:0] in_byte;

   modport source (output valid, output restart, output in_byte, input ready);
   modport sink (input valid, input restart, input in_byte, output ready);
endinterface

// ===== rtl/chdf_rsp_if.sv =====
// Result channel: one decoded word with framing status and running length.
interface chdf_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        is_payload;
   logic        chunk_end;
   logic [1:0]  parse_status;
   logic [2:0]  error_code;
   logic [31:0] total_length;

   modport source (output valid, output out_byte, output is_payload, output chunk_end,
                   output parse_status, output error_code, output total_length,
                   input ready);
   modport sink (input valid, input out_byte, input is_payload, input chunk_end,
                 input parse_status, input error_code, input total_length,
                 output ready);
endinterface

// ===== rtl/chdf_parser.sv =====
// Chunked framing state machine: parser state and the per-word decode step.
module chdf_parser import chdf_pkg::*; #(
   parameter int MAX_SIZE_CHARS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_word_type req_word,
   output rsp_word_type rsp_word
);

   localparam int CNT_W = $clog2(MAX_SIZE_CHARS + 1);

   phase_type        phase_ff, phase_in, e_phase;
   err_type          err_ff, err_in, e_err;
   status_type       halt_ff, halt_in, e_halt;
   logic [31:0]      size_value_ff, size_value_in, e_value;
   logic [CNT_W-1:0] size_count_ff, size_count_in, e_count;
   logic             size_frozen_ff, size_frozen_in, e_frozen;
   logic [30:0]      chunk_len_ff, chunk_len_in, e_len;
   logic [30:0]      chunk_cnt_ff, chunk_cnt_in, e_cnt;
   logic [31:0]      total_ff, total_in, e_total;

   hex_type          hex;
   logic [7:0]       c;
   logic             is_x;
   logic             at_start;
   logic [31:0]      sb_value;
   logic [CNT_W-1:0] sb_count;
   logic             sb_frozen;
   logic             tk_over;
   logic [CNT_W-1:0] tk_count;
   logic             tk_frozen;
   logic [31:0]      tk_value;
   logic [30:0]      cnt_inc;
   logic [32:0]      sum;

   assign c    = req_word.in_byte;
   assign hex  = hex_decode(c);
   assign is_x = (c == CH_LX) || (c == CH_UX);

   // restart clears state ahead of this word
   always_comb begin
      if (req_word.restart) begin
         e_phase  = PH_SIZE_START;
         e_err    = ERR_NONE;
         e_halt   = ST_RUN;
         e_value  = '0;
         e_count  = '0;
         e_frozen = 1'b0;
         e_len    = '0;
         e_cnt    = '0;
         e_total  = '0;
      end else begin
         e_phase  = phase_ff;
         e_err    = err_ff;
         e_halt   = halt_ff;
         e_value  = size_value_ff;
         e_count  = size_count_ff;
         e_frozen = size_frozen_ff;
         e_len    = chunk_len_ff;
         e_cnt    = chunk_cnt_ff;
         e_total  = total_ff;
      end
   end

   // size character accumulation
   assign at_start  = (e_phase == PH_SIZE_START);
   assign sb_value  = at_start ? '0 : e_value;
   assign sb_count  = at_start ? '0 : e_count;
   assign sb_frozen = at_start ? 1'b0 : e_frozen;
   assign tk_over   = (sb_count >= CNT_W'(MAX_SIZE_CHARS));
   assign tk_count  = sb_count + CNT_W'(1);
   assign tk_frozen = sb_frozen |
                      (!hex.ok && !(tk_count == CNT_W'(2) && sb_value == '0));

   always_comb begin
      if (hex.ok && !sb_frozen) begin
         tk_value = (sb_value > SHIFT_LIMIT) ? SIZE_SAT : {sb_value[27:0], hex.digit};
      end else begin
         tk_value = sb_value;
      end
   end

   assign cnt_inc = e_cnt + 31'd1;
   assign sum     = {1'b0, e_total} + {1'b0, e_value};

   // next state
   always_comb begin
      phase_in       = e_phase;
      err_in         = e_err;
      halt_in        = e_halt;
      size_value_in  = e_value;
      size_count_in  = e_count;
      size_frozen_in = e_frozen;
      chunk_len_in   = e_len;
      chunk_cnt_in   = e_cnt;
      total_in       = e_total;
      if (e_halt == ST_RUN) begin
         unique case (e_phase)
            PH_SIZE_START: begin
               if (hex.ok) begin
                  size_value_in  = tk_value;
                  size_count_in  = tk_count;
                  size_frozen_in = tk_frozen;
                  phase_in       = PH_SIZE_DIGITS;
               end else begin
                  halt_in = ST_ERR;
                  err_in  = ERR_BAD_START;
               end
            end
            PH_SIZE_DIGITS: begin
               priority if (hex.ok || is_x) begin
                  if (tk_over) begin
                     halt_in = ST_ERR;
                     err_in  = ERR_TOO_LARGE;
                  end else begin
                     size_value_in  = tk_value;
                     size_count_in  = tk_count;
                     size_frozen_in = tk_frozen;
                  end
               end else if (c == CH_CR) begin
                  phase_in = PH_SIZE_LF;
               end else begin
                  halt_in = ST_ERR;
                  err_in  = ERR_BAD_CHAR;
               end
            end
            PH_SIZE_LF: begin
               priority if (c != CH_LF) begin
                  halt_in = ST_ERR;
                  err_in  = ERR_NO_LF_SIZE;
               end else if (e_value > SIZE_LIMIT) begin
                  halt_in = ST_ERR;
                  err_in  = ERR_TOO_LARGE;
               end else begin
                  total_in     = sum[32] ? '1 : sum[31:0];
                  chunk_len_in = e_value[30:0];
                  chunk_cnt_in = '0;
                  phase_in     = (e_value == '0) ? PH_DATA_CR : PH_DATA;
               end
            end
            PH_DATA: begin
               chunk_cnt_in = cnt_inc;
               if (cnt_inc >= e_len) begin
                  phase_in = PH_DATA_CR;
               end
            end
            PH_DATA_CR: begin
               if (c == CH_CR) begin
                  phase_in = PH_DATA_LF;
               end else begin
                  halt_in = ST_ERR;
                  err_in  = ERR_NO_CR_DATA;
               end
            end
            PH_DATA_LF: begin
               priority if (c != CH_LF) begin
                  halt_in = ST_ERR;
                  err_in  = ERR_NO_LF_DATA;
               end else if (e_len == '0) begin
                  halt_in = ST_DONE;
               end else begin
                  size_value_in  = '0;
                  size_count_in  = '0;
                  size_frozen_in = 1'b0;
                  phase_in       = PH_SIZE_START;
               end
            end
            default: begin
               phase_in = PH_SIZE_START;
               halt_in  = ST_ERR;
               err_in   = ERR_BAD_START;
            end
         endcase
      end
   end

   // result word
   always_comb begin
      rsp_word.is_payload   = (e_halt == ST_RUN) && (e_phase == PH_DATA);
      rsp_word.chunk_end    = rsp_word.is_payload && (cnt_inc >= e_len);
      rsp_word.out_byte     = rsp_word.is_payload ? c : 8'd0;
      rsp_word.parse_status = halt_in;
      rsp_word.error_code   = (halt_in == ST_ERR) ? err_in : ERR_NONE;
      rsp_word.total_length = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SIZE_START;
         err_ff         <= ERR_NONE;
         halt_ff        <= ST_RUN;
         size_value_ff  <= '0;
         size_count_ff  <= '0;
         size_frozen_ff <= 1'b0;
         chunk_len_ff   <= '0;
         chunk_cnt_ff   <= '0;
         total_ff       <= '0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         err_ff         <= err_in;
         halt_ff        <= halt_in;
         size_value_ff  <= size_value_in;
         size_count_ff  <= size_count_in;
         size_frozen_ff <= size_frozen_in;
         chunk_len_ff   <= chunk_len_in;
         chunk_cnt_ff   <= chunk_cnt_in;
         total_ff       <= total_in;
      end
   end

endmodule

// ===== rtl/http_chunked_body_deframer.sv =====
// HTTP chunked body deframer top level: input register, parser, result register.
//
// Usage: feed the raw chunked body one word per handshake on req_chan
// (restart high on the first word of a new body). Each input word yields
// exactly one result word on rsp_chan, in order: the word echoed when it is
// payload, payload and chunk-end flags, parse status, error code and the
// saturating running total of chunk sizes.
// Results are registered: each accepted word passes through the input
// register, then the result register, from which rsp_chan takes it.
// Throughput: one word per cycle while rsp_chan.ready stays high; the
// parse step is a single pass of compare, shift-add and 33-bit add
// between the two registers.
// Reset: synchronous, clears the parser to the start of a size line and
// empties both registers; req_chan.ready is high in the cycle after reset.
// Stall: while rsp_chan.ready is low the result register holds; the input
// register takes a word while it is empty or while its word moves on to the
// result register, else req_chan.ready stays low until the result is taken.
// Completion and errors hold until a word with restart.
module http_chunked_body_deframer import chdf_pkg::*; #(
   parameter int MAX_SIZE_CHARS = 16
) (
   input  logic       clock,
   input  logic       reset,
   chdf_req_if.sink   req_chan,
   chdf_rsp_if.source rsp_chan
);

   logic         in_valid_ff, in_valid_in;
   req_word_type req_word_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word;
   logic         advance;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign in_valid_in  = (req_chan.valid && req_chan.ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   chdf_parser #(
      .MAX_SIZE_CHARS(MAX_SIZE_CHARS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req_word(req_word_ff),
      .rsp_word(rsp_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         req_word_ff <= '{restart: req_chan.restart, in_byte: req_chan.in_byte};
      end
      if (advance) begin
         rsp_word_ff <= rsp_word;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.out_byte     = rsp_word_ff.out_byte;
   assign rsp_chan.is_payload   = rsp_word_ff.is_payload;
   assign rsp_chan.chunk_end    = rsp_word_ff.chunk_end;
   assign rsp_chan.parse_status = rsp_word_ff.parse_status;
   assign rsp_chan.error_code   = rsp_word_ff.error_code;
   assign rsp_chan.total_length = rsp_word_ff.total_length;

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_chan.ready)
      else $error("input stalled with empty result register");

   a_end_is_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.chunk_end |-> rsp_chan.is_payload)
      else $error("chunk end on a non-payload word");

   a_payload_running: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.is_payload |-> rsp_chan.parse_status == ST_RUN)
      else $error("payload word while halted");

   a_error_code_match: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         ((rsp_chan.error_code != ERR_NONE) == (rsp_chan.parse_status == ST_ERR)))
      else $error("error code disagrees with status");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("parsed word lost");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the HTTP chunked body deframer: random framed bodies, scoreboard on each word.
module tb;
   import chdf_pkg::*;

   localparam int MAX_CHARS = 16;
   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_AT = 300;
   localparam int HOLD_LEN = 300;

   logic clock;
   logic reset;

   chdf_req_if req_if();
   chdf_rsp_if rsp_if();

   http_chunked_body_deframer #(.MAX_SIZE_CHARS(MAX_CHARS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   req_word_type body_q[$];
   rsp_word_type decoded_q[$];
   bit restart_next;
   int total_items;
   int words_sent = 0;
   int rsp_seen = 0;
   int failed = 0;
   int idle_cycles = 0;
   int unsigned send_wait, send_calm = 0;
   int unsigned recv_wait, recv_calm = 0;

   phase_type   body_ph;
   logic [31:0] body_size;
   logic [4:0]  body_digits;
   logic        body_frozen;
   logic [30:0] chunk_len;
   logic [30:0] chunk_seen;
   logic [31:0] body_total;
   status_type  body_st;
   err_type     body_err;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int hex_val(logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      if (c >= CH_LA && c <= CH_LF_HEX) return int'(c - CH_LA) + 10;
      if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
      return -1;
   endfunction

   function automatic void clear_size();
      body_size   = '0;
      body_digits = '0;
      body_frozen = 1'b0;
   endfunction

   function automatic void clear_body();
      body_ph = PH_SIZE_START;
      clear_size();
      chunk_len  = '0;
      chunk_seen = '0;
      body_total = '0;
      body_st    = ST_RUN;
      body_err   = ERR_NONE;
   endfunction

   function automatic void halt(err_type e);
      body_st  = ST_ERR;
      body_err = e;
   endfunction

   function automatic void take_size(int d);
      if (body_digits >= MAX_CHARS) begin
         halt(ERR_TOO_LARGE);
      end else begin
         body_digits++;
         if (d < 0) begin
            if (!(body_digits == 5'd2 && body_size == 0)) body_frozen = 1'b1;
         end else if (!body_frozen) begin
            body_size = (body_size > SHIFT_LIMIT) ? SIZE_SAT : {body_size[27:0], 4'(d)};
         end
      end
   endfunction

   function automatic rsp_word_type deframe_word(req_word_type w);
      rsp_word_type r;
      logic [7:0]   c;
      int           d;
      logic [32:0]  sum;
      c = w.in_byte;
      d = hex_val(c);
      r.out_byte   = '0;
      r.is_payload = 1'b0;
      r.chunk_end  = 1'b0;
      if (w.restart) clear_body();
      if (body_st == ST_RUN) begin
         case (body_ph)
            PH_SIZE_START: begin
               if (d >= 0) begin
                  clear_size();
                  take_size(d);
                  body_ph = PH_SIZE_DIGITS;
               end else begin
                  halt(ERR_BAD_START);
               end
            end
            PH_SIZE_DIGITS: begin
               if (d >= 0 || c == CH_LX || c == CH_UX) take_size(d);
               else if (c == CH_CR) body_ph = PH_SIZE_LF;
               else halt(ERR_BAD_CHAR);
            end
            PH_SIZE_LF: begin
               if (c != CH_LF) begin
                  halt(ERR_NO_LF_SIZE);
               end else if (body_size > SIZE_LIMIT) begin
                  halt(ERR_TOO_LARGE);
               end else begin
                  sum = {1'b0, body_total} + {1'b0, body_size};
                  body_total = sum[32] ? '1 : sum[31:0];
                  chunk_len  = body_size[30:0];
                  chunk_seen = '0;
                  body_ph = (body_size == 0) ? PH_DATA_CR : PH_DATA;
               end
            end
            PH_DATA: begin
               r.is_payload = 1'b1;
               r.out_byte   = c;
               chunk_seen   = chunk_seen + 31'd1;
               if (chunk_seen >= chunk_len) begin
                  r.chunk_end = 1'b1;
                  body_ph = PH_DATA_CR;
               end
            end
            PH_DATA_CR: begin
               if (c == CH_CR) body_ph = PH_DATA_LF;
               else halt(ERR_NO_CR_DATA);
            end
            PH_DATA_LF: begin
               if (c != CH_LF) begin
                  halt(ERR_NO_LF_DATA);
               end else if (chunk_len == 0) begin
                  body_st = ST_DONE;
               end else begin
                  clear_size();
                  body_ph = PH_SIZE_START;
               end
            end
            default: halt(ERR_BAD_START);
         endcase
      end
      r.parse_status = body_st;
      r.error_code   = (body_st == ST_ERR) ? body_err : ERR_NONE;
      r.total_length = body_total;
      return r;
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] v);
      if (v < 4'd10) return CH_0 + 8'(v);
      return (($urandom_range(0, 1) != 0) ? CH_LA : CH_UA) + 8'(v) - 8'd10;
   endfunction

   task automatic push_byte(logic [7:0] b);
      req_word_type w;
      w.restart = restart_next;
      w.in_byte = b;
      body_q.push_back(w);
      restart_next = 1'b0;
   endtask

   task automatic push_text(string s, bit first_restart);
      int i;
      restart_next = first_restart;
      for (i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   task automatic push_crlf();
      push_byte(CH_CR);
      push_byte(CH_LF);
   endtask

   task automatic push_size(logic [31:0] n, int zeros, bit prefix);
      int k;
      bit lead;
      logic [3:0] nib;
      if (prefix) begin
         push_byte(CH_0);
         push_byte(($urandom_range(0, 1) != 0) ? CH_LX : CH_UX);
      end
      repeat (zeros) push_byte(CH_0);
      lead = 1'b1;
      for (k = 7; k >= 0; k--) begin
         nib = n[4*k +: 4];
         if (nib != 0 || !lead || k == 0) begin
            lead = 1'b0;
            push_byte(hex_char(nib));
         end
      end
   endtask

   task automatic push_body();
      int sz;
      repeat ($urandom_range(0, 4)) begin
         sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
         push_size(sz, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0,
                   $urandom_range(0, 7) == 0);
         push_crlf();
         repeat (sz) push_byte(8'($urandom_range(0, 255)));
         push_crlf();
      end
      push_size(0, $urandom_range(0, 1), $urandom_range(0, 7) == 0);
      push_crlf();
      push_crlf();
      repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic push_odd_size();
      int k;
      case ($urandom_range(0, 4))
         0: begin
            push_size($urandom | SIZE_SAT, 0, $urandom_range(0, 1) != 0);
            push_crlf();
         end
         1: begin
            k = $urandom_range(1, 15);
            push_size(k, $urandom_range(14, 17), 1'b0);
            push_crlf();
            repeat (k) push_byte(8'($urandom_range(0, 255)));
            push_crlf();
            push_size(0, 0, 1'b0);
            push_crlf();
            push_crlf();
         end
         2: begin
            push_size(($urandom_range(0, 1) != 0) ? SIZE_LIMIT : ($urandom & SIZE_LIMIT) | 32'h100,
                      0, $urandom_range(0, 1) != 0);
            push_crlf();
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
         end
         3: begin
            k = $urandom_range(1, 15);
            push_byte(hex_char(4'(k)));
            push_byte(($urandom_range(0, 1) != 0) ? CH_LX : CH_UX);
            repeat ($urandom_range(0, 3)) push_byte(hex_char(4'($urandom_range(0, 15))));
            push_crlf();
            repeat (k) push_byte(8'($urandom_range(0, 255)));
            push_crlf();
            push_size(0, 0, 1'b0);
            push_crlf();
            push_crlf();
         end
         default: begin
            push_byte(hex_char(4'($urandom_range(1, 15))));
            repeat ($urandom_range(8, 10)) push_byte(hex_char(4'($urandom_range(0, 15))));
            push_crlf();
         end
      endcase
   endtask

   task automatic push_noise();
      string chars;
      chars = "0123456789aAfFgGxX; ";
      repeat ($urandom_range(1, 10)) begin
         restart_next = ($urandom_range(0, 5) == 0);
         case ($urandom_range(0, 3))
            0: push_byte(8'($urandom_range(0, 255)));
            1: push_byte(CH_CR);
            2: push_byte(CH_LF);
            default: push_byte(chars[$urandom_range(0, chars.len() - 1)]);
         endcase
      end
   endtask

   function automatic int unsigned draw_wait(inout int unsigned calm);
      if (calm != 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 60);
         return 0;
      end
      return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failed++;
      end
   endfunction

   always @(posedge clock) begin : sender
      req_word_type w;
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.restart <= 1'b0;
         req_if.in_byte <= '0;
         send_wait      <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            decoded_q.push_back(deframe_word(req_word_type'({req_if.restart, req_if.in_byte})));
            words_sent <= words_sent + 1;
         end
         if (!(req_if.valid && !req_if.ready)) begin
            if (send_wait != 0) begin
               req_if.valid <= 1'b0;
               send_wait    <= send_wait - 1;
            end else if (body_q.size() != 0) begin
               w = body_q.pop_front();
               req_if.valid   <= 1'b1;
               req_if.restart <= w.restart;
               req_if.in_byte <= w.in_byte;
               send_wait      <= draw_wait(send_calm);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : receiver
      rsp_word_type want;
      int unsigned nxt;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_wait    <= 0;
      end else begin
         nxt = recv_wait;
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_seen++;
            if (decoded_q.size() == 0) begin
               $error("result word with no expected word pending");
               failed++;
            end else begin
               want = decoded_q.pop_front();
               check_field("out_byte", 32'(want.out_byte), 32'(rsp_if.out_byte));
               check_field("is_payload", 32'(want.is_payload), 32'(rsp_if.is_payload));
               check_field("chunk_end", 32'(want.chunk_end), 32'(rsp_if.chunk_end));
               check_field("parse_status", 32'(want.parse_status), 32'(rsp_if.parse_status));
               check_field("error_code", 32'(want.error_code), 32'(rsp_if.error_code));
               check_field("total_length", want.total_length, rsp_if.total_length);
            end
            nxt = (rsp_seen == HOLD_AT) ? HOLD_LEN : draw_wait(recv_calm);
         end
         if (nxt != 0) begin
            rsp_if.ready <= 1'b0;
            recv_wait    <= nxt - 1;
         end else begin
            rsp_if.ready <= 1'b1;
            recv_wait    <= 0;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int sel, mark, idx;
      req_word_type w;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.restart = 1'b0;
      req_if.in_byte = '0;
      rsp_if.ready   = 1'b0;
      clear_body();

      push_text("0", 1'b1);
      push_crlf();
      push_crlf();
      push_text("A", 1'b0);
      push_text("g", 1'b1);
      push_text("5", 1'b0);
      push_text("1;", 1'b1);
      push_text("1", 1'b1);
      push_byte(CH_CR);
      push_byte(CH_LX);
      push_text("1", 1'b1);
      push_crlf();
      push_byte(8'h00);
      push_byte(CH_UX);
      push_text("1", 1'b1);
      push_crlf();
      push_byte(8'hFF);
      push_byte(CH_CR);
      push_byte(8'h00);

      while (body_q.size() < 1030) begin
         sel = $urandom_range(0, 99);
         restart_next = 1'b1;
         if (sel < 60) begin
            push_body();
         end else if (sel < 75) begin
            mark = body_q.size();
            push_body();
            idx = $urandom_range(mark, body_q.size() - 1);
            if ($urandom_range(0, 1) != 0) begin
               w = body_q[idx];
               w.in_byte = 8'($urandom_range(0, 255));
               body_q[idx] = w;
            end else begin
               while (body_q.size() > idx) void'(body_q.pop_back());
            end
         end else if (sel < 88) begin
            push_odd_size();
         end else begin
            push_noise();
         end
      end
      total_items = body_q.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (words_sent < total_items || decoded_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (failed == 0 && decoded_q.size() == 0) begin
         $display("tb: success");
      end else begin
         if (decoded_q.size() != 0)
            $error("%0d expected words never arrived", decoded_q.size());
         $display("tb: failure");
      end
      $finish;
   end

endmodule
